FILE: src/tbdc_pkg.sv
// Package for the two-branch diversity combiner: field widths, modes, queue entry type.
// No dependencies.
package tbdc_pkg;
   localparam int MaxCells = 4096;
   localparam int CntW = 13;
   localparam int SumW = 30;
   localparam int DivW = 34;

   typedef enum logic [1:0] {
      MODE_FRAME = 2'd0,
      MODE_CELL  = 2'd1,
      MODE_MRC   = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   // One classified cell pair, passed from the front end to the divider back end.
   typedef struct packed {
      logic               mrc;
      logic               last;
      logic signed [15:0] re_a;
      logic signed [15:0] im_a;
      logic signed [15:0] re_b;
      logic signed [15:0] im_b;
      logic [15:0]        csi_a;
      logic [15:0]        csi_b;
      logic               pick_a;
   } job_type;
endpackage

FILE: src/tbdc_front.sv
// Front end of the combiner: accepts beats, classifies the branch choice, two-entry queue.
// Depends on tbdc_pkg.
module tbdc_front (
   input  logic                clock,
   input  logic                reset,
   input  tbdc_pkg::mode_type  mode,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [127:0]        in_data,
   input  logic                in_last,
   output logic                job_valid,
   input  logic                job_ready,
   output tbdc_pkg::job_type   job
);
   import tbdc_pkg::*;

   job_type    q_ff [2];
   job_type    q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign push      = in_valid && in_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_valid && job_ready;
   assign job       = q_ff[rd_ff];

   always_comb begin
      logic [15:0] ca, cb, qa, qb;
      ca = in_data[47:32];
      cb = in_data[95:80];
      qa = in_data[111:96];
      qb = in_data[127:112];
      q_in.re_a  = in_data[15:0];
      q_in.im_a  = in_data[31:16];
      q_in.csi_a = ca;
      q_in.re_b  = in_data[63:48];
      q_in.im_b  = in_data[79:64];
      q_in.csi_b = cb;
      q_in.last  = in_last;
      q_in.mrc   = (mode == MODE_MRC);
      q_in.pick_a = (mode == MODE_CELL) ? (ca > cb) : (qa > qb);
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rd_in  = rd_ff ^ pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end

`ifndef SYNTHESIS
   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> rd_ff == wr_ff)
      else $error("queue pointers disagree with count");
   a_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !in_ready)
      else $error("full queue accepts");
`endif
endmodule

FILE: src/tbdc_back.sv
// Back end: multiplies, runs a shared restoring divider, keeps frame statistics.
// Depends on tbdc_pkg.
module tbdc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_ready,
   input  tbdc_pkg::job_type  job,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [15:0]        out_re,
   output logic [15:0]        out_im,
   output logic [16:0]        out_csi,
   output logic               out_end,
   output logic [16:0]        out_share
);
   import tbdc_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_ADD   = 7'b0000100,
      ST_DIV   = 7'b0001000,
      ST_NEXT  = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_OUT   = 7'b1000000
   } state_type;

   state_type st_ff, st_in;
   job_type   j_ff;
   logic signed [31:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic [DivW-1:0] num_ff, num_in, rem_ff, rem_in, quo_ff, quo_in, den_ff, den_in;
   logic [5:0]  bit_ff, bit_in;
   logic [1:0]  ph_ff, ph_in;     // 0 re, 1 im, 2 weight, 3 share
   logic        neg_ff, neg_in;
   logic signed [33:0] sre_sum, sim_ff;
   logic [16:0] wgt_ff, wgt_in;
   logic [15:0] ore_ff, ore_in, oim_ff, oim_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [SumW-1:0] sum_ff, sum_in;
   logic        ov_ff, ov_in;
   logic [16:0] share_ff, share_in;
   logic [16:0] csum;
   logic [DivW:0] trial;
   logic [DivW-1:0] qrnd;

   assign csum = {1'b0, j_ff.csi_a} + {1'b0, j_ff.csi_b};
   assign sre_sum = 34'(p0_ff) + 34'(p1_ff);
   assign job_ready = (st_ff == ST_IDLE);
   assign out_valid = ov_ff;
   assign out_re = ore_ff;
   assign out_im = oim_ff;
   assign out_end = j_ff.last;
   assign out_share = share_ff;
   assign out_csi = !j_ff.mrc ? {1'b0, (j_ff.pick_a ? j_ff.csi_a : j_ff.csi_b)} : csum;
   assign trial = {rem_ff, num_ff[DivW-1]} - {1'b0, den_ff};
   assign qrnd = quo_ff;

   function automatic logic [DivW-1:0] mag(input logic signed [33:0] v);
      mag = v[33] ? DivW'(-v) : DivW'(v);
   endfunction

   always_comb begin
      logic [DivW-1:0] d;
      logic [DivW-1:0] half;
      st_in = st_ff; num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      bit_in = bit_ff; ph_in = ph_ff; neg_in = neg_ff; wgt_in = wgt_ff;
      ore_in = ore_ff; oim_in = oim_ff; cnt_in = cnt_ff; sum_in = sum_ff;
      ov_in = ov_ff && !out_ready; share_in = share_ff;
      d = '0; half = '0;
      unique case (st_ff)
         ST_IDLE: if (job_valid) st_in = ST_MUL;
         ST_MUL:  st_in = ST_ADD;
         ST_ADD: begin
            if (!j_ff.mrc) begin
               ore_in = j_ff.pick_a ? j_ff.re_a : j_ff.re_b;
               oim_in = j_ff.pick_a ? j_ff.im_a : j_ff.im_b;
               wgt_in = j_ff.pick_a ? 17'd65536 : 17'd0;
               st_in  = ST_ACC;
            end else if (csum == 17'd0) begin
               ore_in = '0; oim_in = '0; wgt_in = '0;
               st_in  = ST_ACC;
            end else begin
               ph_in = 2'd0;
               d = DivW'(csum);
               half = DivW'(csum >> 1);
               num_in = mag(sre_sum) + half;
               neg_in = sre_sum[33];
               den_in = d; rem_in = '0; quo_in = '0; bit_in = 6'(DivW);
               st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in = {num_ff[DivW-2:0], 1'b0};
            if (!trial[DivW]) begin
               rem_in = trial[DivW-1:0];
               quo_in = {quo_ff[DivW-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[DivW-2:0], num_ff[DivW-1]};
               quo_in = {quo_ff[DivW-2:0], 1'b0};
            end
            bit_in = bit_ff - 6'd1;
            if (bit_ff == 6'd1) st_in = ST_NEXT;
         end
         ST_NEXT: begin
            rem_in = '0; quo_in = '0; bit_in = 6'(DivW);
            half = den_ff >> 1;
            st_in = ST_DIV;
            unique case (ph_ff)
               2'd0: begin
                  ore_in = neg_ff ? 16'(-qrnd) : 16'(qrnd);
                  num_in = mag(sim_ff) + half; neg_in = sim_ff[33]; ph_in = 2'd1;
               end
               2'd1: begin
                  oim_in = neg_ff ? 16'(-qrnd) : 16'(qrnd);
                  num_in = {2'b0, j_ff.csi_a, 16'b0} + half; neg_in = 1'b0; ph_in = 2'd2;
               end
               2'd2: begin
                  wgt_in = 17'(qrnd);
                  st_in = ST_ACC;
               end
               default: begin
                  share_in = 17'(qrnd);
                  cnt_in = '0; sum_in = '0;
                  ov_in = 1'b1;
                  st_in = ST_OUT;
               end
            endcase
         end
         ST_ACC: begin
            if (int'(cnt_ff) < MaxCells) begin
               cnt_in = cnt_ff + 1'b1;
               sum_in = sum_ff + SumW'(wgt_ff);
            end
            if (j_ff.last) begin
               ph_in = 2'd3;
               den_in = DivW'(cnt_in);
               num_in = DivW'(sum_in) + DivW'(cnt_in >> 1);
               rem_in = '0; quo_in = '0; bit_in = 6'(DivW);
               st_in = ST_DIV;
            end else begin
               share_in = '0; ov_in = 1'b1; st_in = ST_OUT;
            end
         end
         ST_OUT: if (!ov_ff || out_ready) begin
            ov_in = 1'b0; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; cnt_ff <= '0; sum_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; sum_ff <= sum_in; ov_ff <= ov_in;
      end
      if (st_ff == ST_IDLE && job_valid) j_ff <= job;
      if (st_ff == ST_MUL) begin
         p0_ff <= j_ff.re_a * $signed({1'b0, j_ff.csi_a});
         p1_ff <= j_ff.re_b * $signed({1'b0, j_ff.csi_b});
         p2_ff <= j_ff.im_a * $signed({1'b0, j_ff.csi_a});
         p3_ff <= j_ff.im_b * $signed({1'b0, j_ff.csi_b});
      end
      if (st_ff == ST_ADD) begin
         sim_ff <= 34'(p2_ff) + 34'(p3_ff);
      end
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      bit_ff <= bit_in; ph_ff <= ph_in; neg_ff <= neg_in; wgt_ff <= wgt_in;
      ore_ff <= ore_in; oim_ff <= oim_in; share_ff <= share_in;
   end

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      job_ready |-> !out_valid || out_ready || st_ff == ST_IDLE)
      else $error("idle with inconsistent output");
   a_cnt: assert property (@(posedge clock) disable iff (reset) int'(cnt_ff) <= MaxCells)
      else $error("cell count overflow");
   a_out: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> st_ff == ST_OUT)
      else $error("output valid outside output state");
`endif
endmodule

FILE: src/two_branch_diversity_combiner.sv
// Top level of the two-branch diversity combiner.
// Depends on tbdc_pkg, tbdc_front and tbdc_back.
//
//  channel | dir | fields (tdata low bit up)
//  req     | in  | re_a im_a csi_a re_b im_b csi_b quality_a quality_b; tlast last_cell
//  rsp     | out | out_re out_im out_csi share_a (padded to 72 bits); tlast frame_end
//  csr     | in  | combine_mode, written on csr_we
//
// In the back end a switched cell needs no division; a maximal ratio cell with a nonzero
// csi sum runs three 34-step divisions in the shared restoring divider, and a
// frame's last cell adds one more division for the share.
// Reset is synchronous and clears the queue, the frame counters and the mode.
// The two-entry queue lets the front accept beats while the back end is busy or
// while a result waits on rsp_tready.
module two_branch_diversity_combiner (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // re_a, im_a, csi_a, re_b, im_b, csi_b, quality_a, quality_b
   input  logic         req_tlast,  // last_cell
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // out_re, out_im, out_csi, share_a, zero pad
   output logic         rsp_tlast   // frame_end
);
   import tbdc_pkg::*;

   mode_type    mode_ff;
   job_type     job;
   logic        job_valid, job_ready;
   logic [15:0] o_re, o_im;
   logic [16:0] o_csi, o_share;

   // Mode register; all four codes are legal, the spare one acts as frame switched.
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= MODE_FRAME;
      else if (csr_we) mode_ff <= mode_type'(csr_wdata);
   end

   tbdc_front u_front (
      .clock, .reset, .mode(mode_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_data(req_tdata), .in_last(req_tlast),
      .job_valid, .job_ready, .job
   );

   tbdc_back u_back (
      .clock, .reset, .job_valid, .job_ready, .job,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_re(o_re), .out_im(o_im), .out_csi(o_csi),
      .out_end(rsp_tlast), .out_share(o_share)
   );

   assign rsp_tdata = {6'b0, o_share, o_csi, o_im, o_re};
endmodule
